FILE: rtl/core/ror_pkg.sv
// Shared types and constants for the in-order release reorder buffer.
// No dependencies; used by ror_front, ror_back and the top level.
package ror_pkg;

  localparam int unsigned SEQ_W       = 16;
  localparam logic [SEQ_W-1:0] SEQ_MAX = 16'hFFFF;
  // Results one input word may cause, its own reject result included.
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             reject;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             status;
    logic             last_of_run;
  } res_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

endpackage

FILE: rtl/core/ror_fifo.sv
// Small register-based FIFO used as the input queue and the result queue.
// Standalone; no package dependency.
module ror_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign wr_fire   = wr_en_i && !full_o;
  assign rd_fire   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(wr_fire) - CNT_W'(rd_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/core/ror_front.sv
// Front end: input queue, window/duplicate classification, hand-off slot.
// Depends on ror_pkg and ror_fifo.
module ror_front #(
  parameter int unsigned WINDOW = 32,
  parameter int unsigned IDX_W  = $clog2(WINDOW)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [ror_pkg::SEQ_W-1:0] seq_num_i,
  input  logic [ror_pkg::SEQ_W-1:0] last_released_i,
  input  logic [IDX_W-1:0]         head_i,
  input  logic [WINDOW-1:0]        bits_i,
  input  logic                     back_idle_i,
  input  logic                     take_i,
  output logic                     cmd_valid_o,
  output ror_pkg::cmd_t            cmd_o,
  output logic [IDX_W-1:0]         cmd_idx_o
);

  localparam int unsigned DIFF_W = ror_pkg::SEQ_W + 1;

  logic [ror_pkg::SEQ_W-1:0] q_seq;
  logic                      q_empty;
  logic                      load;
  logic [DIFF_W-1:0]         diff;
  logic [IDX_W-1:0]          off;
  logic [IDX_W:0]            sum;
  logic [IDX_W:0]            idx_w;
  logic [IDX_W-1:0]          idx;
  logic                      in_win;
  logic                      dup;

  logic                      cmd_valid_q, cmd_valid_d;
  ror_pkg::cmd_t             cmd_q;
  logic [IDX_W-1:0]          cmd_idx_q;

  // Classify only while the back is idle, so its state is settled.
  assign load = back_idle_i && !cmd_valid_q && !q_empty;

  ror_fifo #(
    .WIDTH(ror_pkg::SEQ_W),
    .DEPTH(2)
  ) u_in_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (push_i),
    .wr_data_i(seq_num_i),
    .full_o   (full_o),
    .rd_en_i  (load),
    .rd_data_o(q_seq),
    .empty_o  (q_empty)
  );

  // In window: last < seq <= last + WINDOW. Covers zero and saturation.
  always_comb begin
    diff   = {1'b0, q_seq} - {1'b0, last_released_i};
    in_win = (q_seq > last_released_i) && (diff <= DIFF_W'(WINDOW));
    off    = IDX_W'(diff - 1'b1);
    sum    = {1'b0, head_i} + {1'b0, off};
    idx_w  = (sum >= (IDX_W + 1)'(WINDOW)) ? sum - (IDX_W + 1)'(WINDOW) : sum;
    idx    = idx_w[IDX_W-1:0];
    dup    = in_win && bits_i[idx];
  end

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (take_i) begin
      cmd_valid_d = 1'b0;
    end else if (load) begin
      cmd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q.seq    <= q_seq;
      cmd_q.reject <= !in_win || dup;
      cmd_idx_q    <= idx;
    end
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;
  assign cmd_idx_o   = cmd_idx_q;

  a_no_load_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !cmd_valid_q && back_idle_i)
    else $error("front loaded a word while the hand-off slot was busy");

endmodule

FILE: rtl/core/ror_back.sv
// Back end: arrival bitmap, last released number and the release sequencer.
// Depends on ror_pkg.
module ror_back #(
  parameter int unsigned WINDOW = 32,
  parameter int unsigned IDX_W  = $clog2(WINDOW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  ror_pkg::cmd_t             cmd_i,
  input  logic [IDX_W-1:0]          cmd_idx_i,
  output logic                      take_o,
  output logic                      idle_o,
  output logic [ror_pkg::SEQ_W-1:0] last_released_o,
  output logic [IDX_W-1:0]          head_o,
  output logic [WINDOW-1:0]         bits_o,
  input  logic                      res_full_i,
  output logic                      res_push_o,
  output ror_pkg::res_t             res_o
);

  ror_pkg::back_state_e      state_q, state_d;
  logic [WINDOW-1:0]         bits_q, bits_d;
  logic [ror_pkg::SEQ_W-1:0] last_q, last_d;
  logic [IDX_W-1:0]          head_q, head_d;
  logic [ror_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [IDX_W-1:0]          head_inc;
  logic                      not_sat;
  logic                      start_run;
  logic                      run_end;

  // head_q always points at (last_released + 1) mod WINDOW.
  always_comb begin
    head_inc  = (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
    not_sat   = (last_q != ror_pkg::SEQ_MAX);
    start_run = not_sat && (bits_q[head_q] || (!cmd_i.reject && cmd_idx_i == head_q));
    run_end   = (cnt_q + 1'b1 == ror_pkg::CNT_W'(ror_pkg::MAX_RESULTS)) ||
                (last_q == ror_pkg::SEQ_MAX - 1'b1) ||
                !bits_q[head_inc];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ror_pkg::BACK_IDLE: begin
        if (cmd_valid_i && !res_full_i && start_run) begin
          state_d = ror_pkg::BACK_RUN;
        end
      end
      ror_pkg::BACK_RUN: begin
        if (!res_full_i && run_end) begin
          state_d = ror_pkg::BACK_IDLE;
        end
      end
      default: state_d = ror_pkg::BACK_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    take_o     = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{seq: cmd_i.seq, status: 1'b1, last_of_run: 1'b1};
    bits_d     = bits_q;
    last_d     = last_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      ror_pkg::BACK_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          take_o = 1'b1;
          if (cmd_i.reject) begin
            res_push_o        = 1'b1;
            res_o.last_of_run = !start_run;
            cnt_d             = ror_pkg::CNT_W'(1);
          end else begin
            bits_d[cmd_idx_i] = 1'b1;
            cnt_d             = '0;
          end
        end
      end
      ror_pkg::BACK_RUN: begin
        res_o = '{seq: last_q + 1'b1, status: 1'b0, last_of_run: run_end};
        if (!res_full_i) begin
          res_push_o     = 1'b1;
          bits_d[head_q] = 1'b0;
          last_d         = last_q + 1'b1;
          head_d         = head_inc;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ror_pkg::BACK_IDLE;
      bits_q  <= '0;
      last_q  <= '0;
      head_q  <= IDX_W'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bits_q  <= bits_d;
      last_q  <= last_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  assign idle_o          = (state_q == ror_pkg::BACK_IDLE);
  assign last_released_o = last_q;
  assign head_o          = head_q;
  assign bits_o          = bits_q;

  a_run_not_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ror_pkg::BACK_RUN |-> last_q != ror_pkg::SEQ_MAX)
    else $error("release run active with last released saturated");

  a_run_releases_arrived: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ror_pkg::BACK_RUN |-> bits_q[head_q])
    else $error("release run on a number that has not arrived");

  a_run_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ror_pkg::BACK_RUN |-> cnt_q < ror_pkg::CNT_W'(ror_pkg::MAX_RESULTS))
    else $error("too many results for one input word");

  a_release_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ror_pkg::BACK_RUN && !res_full_i |=> last_q == $past(last_q) + 1'b1)
    else $error("release did not advance last released by one");

endmodule

FILE: rtl/core/in_order_release_reorder_buffer.sv
// Top level of the in-order release reorder buffer.
// Depends on ror_pkg, ror_fifo, ror_front and ror_back.
//
//  channel  | handshake           | words
//  ---------+---------------------+--------------------------------------
//  input    | push / full         | seq_num_i
//  result   | pop / empty         | seq_out_o, status_o, last_of_run_o
//
// An input word passes through the input queue and the hand-off slot,
// then the release sequencer emits one result per cycle while the result
// queue is not full; the single sequencer takes no new word until its run ends.
// Reset clears the bitmap flops at once; no clearing pass is needed.
// Each side stalls on its own through a two-word input and result queue.
module in_order_release_reorder_buffer #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [ror_pkg::SEQ_W-1:0] seq_num_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [ror_pkg::SEQ_W-1:0] seq_out_o,
  output logic                      status_o,
  output logic                      last_of_run_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned RES_W = $bits(ror_pkg::res_t);

  logic                      cmd_valid;
  ror_pkg::cmd_t             cmd;
  logic [IDX_W-1:0]          cmd_idx;
  logic                      take;
  logic                      back_idle;
  logic [ror_pkg::SEQ_W-1:0] last_released;
  logic [IDX_W-1:0]          head;
  logic [WINDOW-1:0]         bits;
  logic                      res_full;
  logic                      res_push;
  ror_pkg::res_t             res_in;
  ror_pkg::res_t             res_out;

  ror_front #(
    .WINDOW(WINDOW),
    .IDX_W (IDX_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .seq_num_i      (seq_num_i),
    .last_released_i(last_released),
    .head_i         (head),
    .bits_i         (bits),
    .back_idle_i    (back_idle),
    .take_i         (take),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_idx_o      (cmd_idx)
  );

  ror_back #(
    .WINDOW(WINDOW),
    .IDX_W (IDX_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_idx_i      (cmd_idx),
    .take_o         (take),
    .idle_o         (back_idle),
    .last_released_o(last_released),
    .head_o         (head),
    .bits_o         (bits),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_in)
  );

  ror_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (res_push),
    .wr_data_i(res_in),
    .full_o   (res_full),
    .rd_en_i  (pop),
    .rd_data_o(res_out),
    .empty_o  (empty)
  );

  assign seq_out_o     = res_out.seq;
  assign status_o      = res_out.status;
  assign last_of_run_o = res_out.last_of_run;

endmodule
